@@ rtl/core/pms_pkg.sv @@
// Shared types, constants and tables for the panel matrix scanner.
package pms_pkg;

  localparam int NumRows = 6;
  localparam logic [7:0] ButtonGapReset = 8'd5;
  localparam logic [7:0] KnobGapReset = 8'd1;
  localparam logic [7:0] PowerKeyCode = 8'h8B;

  typedef enum logic [3:0] {
    PH_CAPTURE = 4'd0,
    PH_SCAN    = 4'd1,
    PH_BTN1    = 4'd2,
    PH_BTN2    = 4'd3,
    PH_BTN3    = 4'd4,
    PH_KNOB1   = 4'd5,
    PH_KNOB2   = 4'd6,
    PH_KNOB3   = 4'd7,
    PH_KNOB4   = 4'd8,
    PH_KNOB5   = 4'd9,
    PH_RELEASE = 4'd10,
    PH_SEND    = 4'd11,
    PH_PWR_REL = 4'd12
  } phase_t;

  typedef enum logic [0:0] {
    REG_BUTTON_GAP = 1'b0,
    REG_KNOB_GAP   = 1'b1
  } reg_idx_t;

  // one result word
  typedef struct packed {
    logic [5:0] row_drive;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [2:0] led_n;
    logic       power_on;
  } result_t;

  function automatic logic [5:0] row_pattern(input logic [2:0] r);
    logic [5:0] p;
    case (r)
      3'd0: p = 6'h3e;
      3'd1: p = 6'h3d;
      3'd2: p = 6'h3b;
      3'd3: p = 6'h37;
      3'd4: p = 6'h2f;
      default: p = 6'h1f;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] knob_mask(input logic [2:0] r);
    logic [7:0] m;
    case (r)
      3'd3: m = 8'h91;
      3'd4: m = 8'hbf;
      default: m = 8'h81;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] knob_a(input logic [2:0] r);
    logic [7:0] c;
    case (r)
      3'd0: c = 8'h14;
      3'd1: c = 8'h16;
      3'd2: c = 8'h18;
      3'd3: c = 8'h1a;
      3'd5: c = 8'h1b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] knob_b(input logic [2:0] r);
    logic [7:0] c;
    case (r)
      3'd0: c = 8'h15;
      3'd1: c = 8'h17;
      3'd2: c = 8'h19;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // press code for row r, column bit b; 0 when no key sits there
  function automatic logic [7:0] press_code(input logic [2:0] r, input logic [2:0] b);
    logic [7:0] c;
    c = 8'h00;
    case (r)
      3'd0: if (b == 3'd0) c = 8'h81; else if (b == 3'd7) c = 8'h8d;
      3'd1: if (b == 3'd0) c = 8'h83; else if (b == 3'd7) c = 8'h8e;
      3'd2: if (b == 3'd0) c = 8'h85; else if (b == 3'd7) c = 8'h8f;
      3'd3: if (b == 3'd0) c = 8'h87; else if (b == 3'd4) c = 8'h88;
            else if (b == 3'd7) c = 8'h90;
      3'd4: begin
        case (b)
          3'd0: c = 8'h89;
          3'd1: c = 8'h8a;
          3'd2: c = 8'h84;
          3'd3: c = 8'h8c;
          3'd4: c = 8'h86;
          3'd5: c = 8'h82;
          3'd7: c = 8'h91;
          default: c = 8'h00;
        endcase
      end
      3'd5: if (b == 3'd7) c = 8'h92;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/pms_cfg_regs.sv @@
// APB register file holding the two debounce gap settings.
module pms_cfg_regs
  import pms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  output logic [7:0] button_gap,
  output logic [7:0] knob_gap
);

  logic [7:0] button_gap_r;
  logic [7:0] knob_gap_r;
  logic       wr_en;
  logic       in_range;
  reg_idx_t   idx;

  assign pready   = 1'b1;
  assign in_range = (paddr[1:0] == 2'b00) && !paddr[2] ? 1'b1 :
                    (paddr == 3'd4);
  assign idx      = reg_idx_t'(paddr[2]);
  assign wr_en    = psel && penable && pwrite && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_gap_r <= ButtonGapReset;
      knob_gap_r   <= KnobGapReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_BUTTON_GAP: button_gap_r <= pwdata[7:0];
        REG_KNOB_GAP:   knob_gap_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (in_range) begin
      unique case (idx)
        REG_BUTTON_GAP: prdata = {24'd0, button_gap_r};
        REG_KNOB_GAP:   prdata = {24'd0, knob_gap_r};
        default: prdata = 32'd0;
      endcase
    end
  end

  assign button_gap = button_gap_r;
  assign knob_gap   = knob_gap_r;

endmodule

@@ rtl/core/pms_engine.sv @@
// Scan and link state update: one word in, one result word out per cycle while step is high.
module pms_engine
  import pms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       action,
  input  logic [7:0] column_sample,
  input  logic [7:0] rx_byte,
  input  logic [7:0] button_gap,
  input  logic [7:0] knob_gap,
  output result_t    result
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] row_r, row_nxt;
  logic [7:0] prev_r [NumRows];
  logic [7:0] prev_wdata;
  logic       prev_we;
  logic [7:0] gap_r, gap_nxt;
  logic [7:0] sav0_r, sav0_nxt, sav1_r, sav1_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [7:0] rw_code_r, rw_code_nxt;
  logic [2:0] rw_bit_r, rw_bit_nxt;
  logic       pwr_r, pwr_nxt;
  logic [2:0] led_r, led_nxt;

  logic [7:0] s, prev, km, ka, kb, hit_code, kcode, gap_load;
  logic [2:0] hit_bit, nxt_row;
  logic       hit, ksent, is_knob;
  logic [6:0] kod;

  assign s       = column_sample;
  assign prev    = prev_r[row_r];
  assign km      = knob_mask(row_r);
  assign ka      = knob_a(row_r);
  assign kb      = knob_b(row_r);
  assign nxt_row = (row_r == 3'(NumRows - 1)) ? 3'd0 : row_r + 3'd1;
  assign kod     = rx_byte[6:0];
  assign is_knob = (phase_r >= PH_KNOB1) && (phase_r <= PH_KNOB5);
  assign gap_load = is_knob ? knob_gap : button_gap;

  // first low key bit with a code, lowest bit first
  always_comb begin
    hit = 1'b0;
    hit_bit = 3'd0;
    hit_code = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!s[b] && press_code(row_r, 3'(b)) != 8'd0) begin
        hit = 1'b1;
        hit_bit = 3'(b);
        hit_code = press_code(row_r, 3'(b));
      end
    end
  end

  // knob pairs: second bit wins, second pair only if first did not send
  always_comb begin
    ksent = 1'b0;
    kcode = pend_r;
    if (ka != 8'd0 && s[1] && s[2]) begin
      if (!prev[1]) begin kcode = ka; ksent = 1'b1; end
      if (!prev[2]) begin kcode = ka | 8'h80; ksent = 1'b1; end
    end
    if (!ksent && kb != 8'd0 && s[4] && s[5]) begin
      if (!prev[4]) kcode = kb;
      if (!prev[5]) kcode = kb | 8'h80;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    row_nxt = row_r;
    gap_nxt = gap_r;
    sav0_nxt = sav0_r;
    sav1_nxt = sav1_r;
    pend_nxt = pend_r;
    rw_code_nxt = rw_code_r;
    rw_bit_nxt = rw_bit_r;
    pwr_nxt = pwr_r;
    led_nxt = led_r;
    prev_we = 1'b0;
    prev_wdata = s;
    if (action) begin
      if (kod >= 7'd1 && kod <= 7'd3) begin
        if (rx_byte[7]) led_nxt[kod[1:0] - 2'd1] = 1'b0;
        else led_nxt[kod[1:0] - 2'd1] = 1'b1;
      end else if (kod == 7'd4 && pwr_r) begin
        pwr_nxt = 1'b0;
        led_nxt = 3'b111;
      end
      pend_nxt = 8'd0;
    end else begin
      case (phase_r)
        PH_CAPTURE: begin
          prev_we = 1'b1;
          row_nxt = nxt_row;
          if (nxt_row == 3'd0) phase_nxt = PH_SCAN;
        end
        PH_RELEASE: begin
          if (s[rw_bit_r]) begin
            sav1_nxt = s;
            if (pend_r == 8'd0) begin
              pend_nxt = rw_code_r;
              prev_we = 1'b1;
              rw_code_nxt = 8'd0; rw_bit_nxt = 3'd0;
              row_nxt = nxt_row; phase_nxt = PH_SCAN;
            end else phase_nxt = PH_SEND;
          end
        end
        PH_SEND: begin
          if (pend_r == 8'd0) begin
            pend_nxt = rw_code_r;
            prev_we = 1'b1; prev_wdata = sav1_r;
            rw_code_nxt = 8'd0; rw_bit_nxt = 3'd0;
            row_nxt = nxt_row; phase_nxt = PH_SCAN;
          end
        end
        PH_PWR_REL: begin
          if (s[0]) begin
            prev_we = 1'b1;
            row_nxt = nxt_row; phase_nxt = PH_SCAN;
          end
        end
        PH_BTN1, PH_BTN2, PH_BTN3, PH_KNOB1, PH_KNOB2,
        PH_KNOB3, PH_KNOB4, PH_KNOB5: begin
          if (gap_r > 8'd1) gap_nxt = gap_r - 8'd1;
          else begin
            gap_nxt = gap_load;
            if (phase_r == PH_BTN1) begin
              sav0_nxt = s; phase_nxt = PH_BTN2;
            end else if (phase_r == PH_BTN2) begin
              sav1_nxt = s; phase_nxt = PH_BTN3;
            end else if (phase_r == PH_KNOB1) begin
              sav1_nxt = s; phase_nxt = PH_KNOB2;
            end else if ((phase_r == PH_BTN3 && (sav0_r != sav1_r || sav1_r != s)) ||
                         (phase_r != PH_BTN3 && s != sav1_r)) begin
              row_nxt = nxt_row; phase_nxt = PH_SCAN;
            end else if (phase_r != PH_BTN3 && phase_r != PH_KNOB5) begin
              phase_nxt = phase_t'(phase_r + 4'd1);
            end else begin
              // decode a stable sample
              if (row_r == 3'd5 && !s[0]) begin
                if (!pwr_r) begin
                  pwr_nxt = 1'b1; phase_nxt = PH_PWR_REL;
                end else begin
                  sav1_nxt = s;
                  if (pend_r == 8'd0) begin
                    pend_nxt = PowerKeyCode;
                    prev_we = 1'b1;
                    rw_code_nxt = 8'd0; rw_bit_nxt = 3'd0;
                    row_nxt = nxt_row; phase_nxt = PH_SCAN;
                  end else begin
                    rw_code_nxt = PowerKeyCode;
                    rw_bit_nxt = 3'd0; phase_nxt = PH_SEND;
                  end
                end
              end else if (hit) begin
                pend_nxt = hit_code;
                rw_code_nxt = {1'b0, hit_code[6:0]};
                rw_bit_nxt = hit_bit;
                phase_nxt = PH_RELEASE;
              end else begin
                pend_nxt = kcode;
                prev_we = 1'b1;
                row_nxt = nxt_row; phase_nxt = PH_SCAN;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_SCAN;
          if (s != prev) begin
            if ((s & km) != km) begin
              phase_nxt = PH_BTN1; gap_nxt = button_gap;
            end else begin
              phase_nxt = PH_KNOB1; gap_nxt = knob_gap;
            end
          end else row_nxt = nxt_row;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CAPTURE;
      row_r <= 3'd0;
      gap_r <= 8'd0;
      sav0_r <= 8'd0;
      sav1_r <= 8'd0;
      pend_r <= 8'd0;
      rw_code_r <= 8'd0;
      rw_bit_r <= 3'd0;
      pwr_r <= 1'b0;
      led_r <= 3'b111;
    end else if (step) begin
      phase_r <= phase_nxt;
      row_r <= row_nxt;
      gap_r <= gap_nxt;
      sav0_r <= sav0_nxt;
      sav1_r <= sav1_nxt;
      pend_r <= pend_nxt;
      rw_code_r <= rw_code_nxt;
      rw_bit_r <= rw_bit_nxt;
      pwr_r <= pwr_nxt;
      led_r <= led_nxt;
    end
  end

  // row values are all written by the capture pass before use
  always_ff @(posedge clk) begin
    if (step && !action && prev_we) prev_r[row_r] <= prev_wdata;
  end

  always_comb begin
    result.row_drive = row_pattern(row_nxt);
    result.tx_byte   = action ? pend_r : 8'd0;
    result.tx_valid  = action;
    result.led_n     = led_nxt;
    result.power_on  = pwr_nxt;
  end

endmodule

@@ rtl/core/pms_out_reg.sv @@
// Result register with a skid stage between engine and receiver.
module pms_out_reg
  import pms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_word,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_word
);

  logic    main_v_r, skid_v_r;
  result_t main_r, skid_r;
  logic    take, pop;

  assign in_stall = skid_v_r;
  assign take     = in_valid && !skid_v_r;
  assign pop      = main_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || pop) begin
        main_v_r <= skid_v_r || take;
        skid_v_r <= 1'b0;
      end else if (take) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || pop) main_r <= skid_v_r ? skid_r : in_word;
    if (take && main_v_r && !pop) skid_r <= in_word;
  end

  assign out_valid = main_v_r;
  assign out_word  = main_r;

endmodule

@@ rtl/core/panel_matrix_scanner.sv @@
// Panel matrix scanner top level.
// Input channel: one word per scan tick (action 0, column_sample holds the
// active-low columns of the row named by the last row_drive) or link
// exchange (action 1, rx_byte holds the command). Every word gives exactly
// one result word: the next row_drive pattern, the returned pending code
// with tx_valid on exchanges, the three LED drives and the power flag.
// The state update runs in the accept cycle, and the result is registered
// in the output stage. Throughput is one word per cycle while the receiver
// does not stall; a combinational engine feeds a two-entry output stage.
// When the receiver stalls, the output stage absorbs one more word and then
// raises in_stall until the receiver takes a result.
// Reset (synchronous, rst_n low) starts a capture pass over all six rows,
// clears pending codes, turns power off, sets all LEDs dark and loads the
// gap registers with 5 (button) and 1 (knob).
// Gap registers sit at APB byte addresses 0 and 4; write them only while
// no word is in flight.
module panel_matrix_scanner
  import pms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_column_sample,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_row_drive,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_led_chan1_n,
  output logic        out_led_chan2_n,
  output logic        out_led_sync_n,
  output logic        out_power_on,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] button_gap, knob_gap;
  result_t    eng_word, out_word;
  logic       step;

  assign step = in_valid && !in_stall;

  pms_cfg_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .button_gap, .knob_gap
  );

  pms_engine u_engine (
    .clk, .rst_n, .step,
    .action(in_action), .column_sample(in_column_sample), .rx_byte(in_rx_byte),
    .button_gap, .knob_gap, .result(eng_word)
  );

  pms_out_reg u_out (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_word(eng_word),
    .out_valid, .out_stall, .out_word
  );

  assign out_row_drive   = out_word.row_drive;
  assign out_tx_byte     = out_word.tx_byte;
  assign out_tx_valid    = out_word.tx_valid;
  assign out_led_chan1_n = out_word.led_n[0];
  assign out_led_chan2_n = out_word.led_n[1];
  assign out_led_sync_n  = out_word.led_n[2];
  assign out_power_on    = out_word.power_on;

endmodule

@@ rtl/core/pms_checker.sv @@
// Port-level checks for the panel matrix scanner, bound to the top level.
module pms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_row_drive,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_power_on,
  input logic       out_led_chan1_n,
  input logic       out_led_chan2_n,
  input logic       out_led_sync_n
);

  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(~out_row_drive))
    else $error("row drive not one-hot low");

  a_scan_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'd0)
    else $error("scan result carries a code");

  a_off_leds_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(!out_stall) && $past(out_power_on)
    && !out_power_on && out_tx_valid
    |-> out_led_chan1_n && out_led_chan2_n && out_led_sync_n)
    else $error("power off left an LED lit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_drive))
    else $error("stalled result changed");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind panel_matrix_scanner pms_checker u_pms_checker (.*);

@@ bench/tb_panel_matrix_scanner.sv @@
// Testbench for panel_matrix_scanner: predicts every result word and checks it in order.
module tb_panel_matrix_scanner;
  import pms_pkg::*;

  // Predicts the scanner state and holds the result words still to come.
  class scan_scoreboard;
    bit [7:0] btn_gap = ButtonGapReset;
    bit [7:0] knob_gap = KnobGapReset;
    int       row;
    phase_t   ph = PH_CAPTURE;
    bit [7:0] gap, sv0, sv1, pend;
    bit [7:0] prev [6];
    bit [7:0] rel_code;
    bit [2:0] rel_bit;
    bit       pwr;
    bit [2:0] led = 3'b111;
    result_t  pending_words [$];
    int       errors;

    function int key_num(int r);
      case (r)
        3: return 3;
        4: return 7;
        5: return 1;
        default: return 2;
      endcase
    endfunction

    // {column bit, press code}
    function bit [10:0] key_at(int r, int k);
      case (r * 8 + k)
        0: return {3'd0, 8'h81};
        1: return {3'd7, 8'h8d};
        8: return {3'd0, 8'h83};
        9: return {3'd7, 8'h8e};
        16: return {3'd0, 8'h85};
        17: return {3'd7, 8'h8f};
        24: return {3'd0, 8'h87};
        25: return {3'd4, 8'h88};
        26: return {3'd7, 8'h90};
        32: return {3'd0, 8'h89};
        33: return {3'd1, 8'h8a};
        34: return {3'd2, 8'h84};
        35: return {3'd3, 8'h8c};
        36: return {3'd4, 8'h86};
        37: return {3'd5, 8'h82};
        38: return {3'd7, 8'h91};
        default: return {3'd7, 8'h92};
      endcase
    endfunction

    function bit [7:0] mask_of(int r);
      return (r == 3) ? 8'h91 : (r == 4) ? 8'hbf : 8'h81;
    endfunction

    function bit [7:0] knob_lo(int r);
      case (r)
        0: return 8'h14;
        1: return 8'h16;
        2: return 8'h18;
        3: return 8'h1a;
        5: return 8'h1b;
        default: return 8'h00;
      endcase
    endfunction

    function bit [7:0] knob_hi(int r);
      return (r < 3) ? 8'h15 + 8'(2 * r) : 8'h00;
    endfunction

    function void advance();
      row = (row + 1) % 6;
      ph = PH_SCAN;
    endfunction

    function void finish_send(int r);
      pend = rel_code;
      prev[r] = sv1;
      rel_code = 0;
      rel_bit = 0;
      advance();
    endfunction

    function void queue_send(int r, bit [7:0] s, bit [7:0] code);
      sv1 = s;
      rel_code = code;
      rel_bit = 0;
      if (pend == 0) finish_send(r);
      else ph = PH_SEND;
    endfunction

    function bit knob_pair(int r, bit [7:0] s, bit [7:0] lo, bit [7:0] code);
      bit sent;
      bit [7:0] hi;
      sent = 0;
      hi = lo << 1;
      if (code == 0 || (s & lo) == 0 || (s & hi) == 0) return 0;
      if ((prev[r] & lo) == 0) begin
        pend = code;
        sent = 1;
      end
      if ((prev[r] & hi) == 0) begin
        pend = code | 8'h80;
        sent = 1;
      end
      return sent;
    endfunction

    function void decode(int r, bit [7:0] s);
      bit [10:0] e;
      int k;
      if (r == 5 && !s[0]) begin
        if (!pwr) begin
          pwr = 1;
          ph = PH_PWR_REL;
        end else queue_send(r, s, PowerKeyCode);
        return;
      end
      for (k = 0; k < key_num(r); k++) begin
        e = key_at(r, k);
        if (!s[e[10:8]]) begin
          pend = e[7:0];
          rel_code = e[7:0] & 8'h7f;
          rel_bit = e[10:8];
          ph = PH_RELEASE;
          return;
        end
      end
      if (!knob_pair(r, s, 8'h02, knob_lo(r))) void'(knob_pair(r, s, 8'h10, knob_hi(r)));
      prev[r] = s;
      advance();
    endfunction

    function void scan_tick(bit [7:0] s);
      int r;
      r = row;
      case (ph)
        PH_CAPTURE: begin
          prev[r] = s;
          row = (r + 1) % 6;
          if (row == 0) ph = PH_SCAN;
          return;
        end
        PH_RELEASE: begin
          if (s[rel_bit]) begin
            sv1 = s;
            if (pend == 0) finish_send(r);
            else ph = PH_SEND;
          end
          return;
        end
        PH_SEND: begin
          if (pend == 0) finish_send(r);
          return;
        end
        PH_PWR_REL: begin
          if (s[0]) begin
            prev[r] = s;
            advance();
          end
          return;
        end
        default: ;
      endcase
      if (ph >= PH_BTN1 && ph <= PH_KNOB5) begin
        if (gap > 1) begin
          gap--;
          return;
        end
        gap = (ph >= PH_KNOB1) ? knob_gap : btn_gap;
        case (ph)
          PH_BTN1: begin
            sv0 = s;
            ph = PH_BTN2;
          end
          PH_BTN2: begin
            sv1 = s;
            ph = PH_BTN3;
          end
          PH_BTN3: begin
            if (sv0 == sv1 && sv1 == s) decode(r, s);
            else advance();
          end
          PH_KNOB1: begin
            sv1 = s;
            ph = PH_KNOB2;
          end
          default: begin
            if (s != sv1) advance();
            else if (ph == PH_KNOB5) decode(r, s);
            else ph = phase_t'(ph + 1);
          end
        endcase
        return;
      end
      ph = PH_SCAN;
      if (s != prev[r]) begin
        if ((s & mask_of(r)) != mask_of(r)) begin
          ph = PH_BTN1;
          gap = btn_gap;
        end else begin
          ph = PH_KNOB1;
          gap = knob_gap;
        end
      end else advance();
    endfunction

    function void note_word(bit act, bit [7:0] col, bit [7:0] rx);
      result_t w;
      bit [7:0] tx;
      bit [6:0] cmd;
      tx = 0;
      cmd = rx[6:0];
      if (act) begin
        if (cmd >= 1 && cmd <= 3) begin
          if (rx[7]) led[cmd - 1] = 1'b0;
          else led[cmd - 1] = 1'b1;
        end else if (cmd == 4 && pwr) begin
          pwr = 0;
          led = 3'b111;
        end
        tx = pend;
        pend = 0;
      end else scan_tick(col);
      w.row_drive = ~(6'd1 << row);
      w.tx_byte = tx;
      w.tx_valid = act;
      w.led_n = led;
      w.power_on = pwr;
      pending_words.push_back(w);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_word(result_t got);
      result_t w;
      if (pending_words.size() == 0) begin
        report("unexpected word", got.tx_byte, 8'h00);
        return;
      end
      w = pending_words.pop_front();
      if (got.row_drive !== w.row_drive) report("row_drive", 8'(got.row_drive), 8'(w.row_drive));
      if (got.tx_byte !== w.tx_byte) report("tx_byte", got.tx_byte, w.tx_byte);
      if (got.tx_valid !== w.tx_valid) report("tx_valid", 8'(got.tx_valid), 8'(w.tx_valid));
      if (got.led_n !== w.led_n) report("led_n", 8'(got.led_n), 8'(w.led_n));
      if (got.power_on !== w.power_on) report("power_on", 8'(got.power_on), 8'(w.power_on));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_action = 0;
  logic [7:0]  in_column_sample = 8'hff;
  logic [7:0]  in_rx_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [5:0]  out_row_drive;
  logic [7:0]  out_tx_byte;
  logic        out_tx_valid;
  logic        out_led_chan1_n, out_led_chan2_n, out_led_sync_n, out_power_on;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scan_scoreboard sb = new();
  int       send_idle_pct, recv_stall_pct;
  int       hold_off;
  int       quiet_cycles;
  bit [7:0] panel [6];

  panel_matrix_scanner dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.row_drive = out_row_drive;
      got.tx_byte = out_tx_byte;
      got.tx_valid = out_tx_valid;
      got.led_n = {out_led_sync_n, out_led_chan2_n, out_led_chan1_n};
      got.power_on = out_power_on;
      sb.check_word(got);
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // call at a falling edge; returns at a falling edge with the word accepted
  task automatic send_word(bit act, bit [7:0] col, bit [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_column_sample <= col;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(act, col, rx);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [7:0] value);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= 3'(idx) << 2;
    cfg_pwdata <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (idx == REG_BUTTON_GAP) sb.btn_gap = value;
    else sb.knob_gap = value;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // panel moves now and then; the sample follows the row being driven
  task automatic random_word();
    int r;
    bit [7:0] col, rx;
    if ($urandom_range(39) == 0) begin
      r = $urandom_range(5);
      case ($urandom_range(4))
        0, 1: panel[r] = 8'hff;
        2: panel[r] = 8'hff & ~(8'd1 << $urandom_range(7));
        3: panel[r] = panel[r] ^ (8'h36 & 8'($urandom));
        default: panel[r] = 8'($urandom);
      endcase
    end
    if ($urandom_range(9) == 0) begin
      rx = ($urandom_range(3) == 0) ? 8'($urandom)
           : {1'($urandom), 7'($urandom_range(5))};
      send_word(1, 8'($urandom), rx);
    end else begin
      col = ($urandom_range(19) == 0) ? 8'($urandom) : panel[sb.row];
      send_word(0, col, 8'($urandom));
    end
  endtask

  initial begin
    int p, i;
    bit [7:0] dir_rx [10];
    dir_rx = '{8'h81, 8'h82, 8'h83, 8'h01, 8'h02, 8'h03, 8'h04, 8'h84, 8'h00, 8'hff};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    quiet_cycles = 0;
    foreach (panel[k]) panel[k] = 8'hff;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // capture pass at the sample extremes, then every link command
    for (i = 0; i < 6; i++) send_word(0, (i == 2) ? 8'h00 : 8'hff, 8'h00);
    foreach (dir_rx[k]) send_word(1, 8'h00, dir_rx[k]);
    for (i = 0; i < 8; i++) send_word(0, (sb.row == 5) ? 8'hfe : 8'hff, 8'h00);
    send_word(1, 8'hff, 8'h84);
    drain();
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(REG_BUTTON_GAP, 8'd1);
          write_reg(REG_KNOB_GAP, 8'd1);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_BUTTON_GAP, 8'd255);
          write_reg(REG_KNOB_GAP, 8'd255);
          send_idle_pct = 87;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_BUTTON_GAP, 8'd2);
          write_reg(REG_KNOB_GAP, 8'd3);
          send_idle_pct = 0;
          recv_stall_pct = 87;
        end
        3: begin
          write_reg(REG_BUTTON_GAP, 8'($urandom_range(1, 6)));
          write_reg(REG_KNOB_GAP, 8'($urandom_range(1, 6)));
          send_idle_pct = 18;
          recv_stall_pct = 18;
        end
        default: begin
          write_reg(REG_BUTTON_GAP, 8'd1);
          write_reg(REG_KNOB_GAP, 8'd2);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (i = 0; i < 350; i++) begin
        if (p == 4 && i == 100) hold_off = 80;
        random_word();
      end
      drain();
    end
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
